/* hdl/dks_pkg.sv */
// Shared types and constants of the delayed key scheduler.
package dks_pkg;

   localparam int PAYLOAD_W = 40;
   localparam int KIND_W    = 8;
   localparam int DELAY_W   = 23;
   localparam int CODE_W    = 8;
   localparam int OP_W      = 3;
   localparam int COUNT_W   = 5;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;

   localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd0;
   localparam logic [OP_W-1:0] OP_CANCEL   = 3'd1;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd2;
   localparam logic [OP_W-1:0] OP_POP      = 3'd3;
   localparam logic [OP_W-1:0] OP_PUSH     = 3'd4;

   typedef struct packed {
      logic capture;
      logic scan_run;
      logic pop_read;
      logic push_write;
      logic rsp_load;
   } dks_cmd_type;

   typedef struct packed {
      logic op_scan;
      logic op_pop;
      logic op_push;
      logic scan_last;
      logic rsp_busy;
   } dks_stat_type;

endpackage

/* hdl/dks_ctrl.sv */
// Sequencing state machine of the delayed key scheduler.
module dks_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  dks_pkg::dks_stat_type stat,
   output dks_pkg::dks_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_POP  = 5'b00100,
      S_PUSH = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.capture = 1'b1;
               if (stat.op_scan) begin
                  state_in = S_SCAN;
               end else if (stat.op_pop) begin
                  state_in = S_POP;
               end else if (stat.op_push) begin
                  state_in = S_PUSH;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_last) begin
               state_in = S_RESP;
            end
         end
         S_POP: begin
            cmd.pop_read = 1'b1;
            state_in     = S_RESP;
         end
         S_PUSH: begin
            cmd.push_write = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/dks_datapath.sv */
// Slot table, output stack and result register of the delayed key scheduler.
module dks_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [dks_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [dks_pkg::OP_W-1:0]          req_tuser,
   output logic [dks_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  dks_pkg::dks_cmd_type              cmd,
   output dks_pkg::dks_stat_type             stat
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [dks_pkg::OP_W-1:0]      op_ff;
   logic [dks_pkg::PAYLOAD_W-1:0] pay_ff;
   logic [dks_pkg::KIND_W-1:0]    kind_ff;
   logic [dks_pkg::DELAY_W-1:0]   delay_ff;
   logic [dks_pkg::CODE_W-1:0]    code_ff;

   logic [ENTRIES-1:0] used_ff, used_in;
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [CNT_W-1:0]   depth_m1;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   proc_idx_ff;
   logic               proc_vld_ff, proc_vld_in;
   logic               placed_ff, placed_in;
   logic               drop_ff, drop_in;
   logic               pop_hit_ff, pop_hit_in;

   logic [dks_pkg::PAYLOAD_W-1:0] slot_pay_mem [ENTRIES];
   logic [dks_pkg::KIND_W-1:0]    slot_kind_mem [ENTRIES];
   logic [dks_pkg::DELAY_W-1:0]   slot_delay_mem [ENTRIES];
   logic [dks_pkg::PAYLOAD_W-1:0] stack_pay_mem [ENTRIES];
   logic [dks_pkg::KIND_W-1:0]    stack_kind_mem [ENTRIES];

   logic [dks_pkg::PAYLOAD_W-1:0] rd_pay_ff;
   logic [dks_pkg::KIND_W-1:0]    rd_kind_ff;
   logic [dks_pkg::DELAY_W-1:0]   rd_delay_ff;
   logic [dks_pkg::PAYLOAD_W-1:0] top_pay_ff;
   logic [dks_pkg::KIND_W-1:0]    top_kind_ff;

   logic                          slot_full_we, slot_delay_we;
   logic [dks_pkg::DELAY_W-1:0]   slot_delay_wd;
   logic                          push_en, push_ok;
   logic [dks_pkg::PAYLOAD_W-1:0] push_pay;
   logic [dks_pkg::KIND_W-1:0]    push_kind;
   logic                          proc_en;
   logic [CNT_W+4:0]              count_wide;

   logic                          rsp_valid_ff;
   logic [dks_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign depth_m1 = depth_ff - 1'b1;
   assign proc_en  = cmd.scan_run && proc_vld_ff;

   assign stat.op_scan   = (req_tuser == dks_pkg::OP_SCHEDULE) ||
                           (req_tuser == dks_pkg::OP_CANCEL) ||
                           (req_tuser == dks_pkg::OP_TICK);
   assign stat.op_pop    = (req_tuser == dks_pkg::OP_POP);
   assign stat.op_push   = (req_tuser == dks_pkg::OP_PUSH);
   assign stat.scan_last = proc_en && (proc_idx_ff == IDX_W'(ENTRIES - 1));
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_tready;

   always_comb begin
      used_in       = used_ff;
      placed_in     = placed_ff;
      drop_in       = drop_ff;
      pop_hit_in    = pop_hit_ff;
      depth_in      = depth_ff;
      rd_idx_in     = rd_idx_ff;
      proc_vld_in   = proc_vld_ff;
      slot_full_we  = 1'b0;
      slot_delay_we = 1'b0;
      slot_delay_wd = rd_delay_ff - 1'b1;
      push_en       = 1'b0;
      push_pay      = pay_ff;
      push_kind     = kind_ff;

      if (cmd.capture) begin
         rd_idx_in   = '0;
         proc_vld_in = 1'b0;
         placed_in   = 1'b0;
         drop_in     = 1'b0;
         pop_hit_in  = 1'b0;
      end

      if (cmd.scan_run) begin
         proc_vld_in = (rd_idx_ff < CNT_W'(ENTRIES));
         if (proc_vld_in) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end

      if (proc_en) begin
         case (op_ff)
            dks_pkg::OP_SCHEDULE: begin
               if (!used_ff[proc_idx_ff] && !placed_ff) begin
                  slot_full_we           = 1'b1;
                  slot_delay_wd          = delay_ff;
                  used_in[proc_idx_ff]   = 1'b1;
                  placed_in              = 1'b1;
               end
            end
            dks_pkg::OP_CANCEL: begin
               if (used_ff[proc_idx_ff]) begin
                  if (rd_pay_ff[23:16] == code_ff) begin
                     used_in[proc_idx_ff] = 1'b0;
                  end
               end
            end
            dks_pkg::OP_TICK: begin
               if (used_ff[proc_idx_ff]) begin
                  if (rd_delay_ff != '0) begin
                     slot_delay_we = 1'b1;
                  end else begin
                     push_en              = 1'b1;
                     push_pay             = rd_pay_ff;
                     push_kind            = rd_kind_ff;
                     used_in[proc_idx_ff] = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
         if (stat.scan_last && (op_ff == dks_pkg::OP_SCHEDULE) && !placed_in) begin
            drop_in = 1'b1;
         end
      end

      if (cmd.push_write) begin
         push_en = 1'b1;
      end

      push_ok = push_en && (depth_ff < CNT_W'(ENTRIES));
      if (push_en) begin
         if (push_ok) begin
            depth_in = depth_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end

      if (cmd.pop_read) begin
         pop_hit_in = (depth_ff != '0);
         if (pop_hit_in) begin
            depth_in = depth_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot_full_we) begin
         slot_pay_mem[proc_idx_ff]  <= pay_ff;
         slot_kind_mem[proc_idx_ff] <= kind_ff;
      end
      if (slot_full_we || slot_delay_we) begin
         slot_delay_mem[proc_idx_ff] <= slot_delay_wd;
      end
      rd_pay_ff   <= slot_pay_mem[rd_idx_ff[IDX_W-1:0]];
      rd_kind_ff  <= slot_kind_mem[rd_idx_ff[IDX_W-1:0]];
      rd_delay_ff <= slot_delay_mem[rd_idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         stack_pay_mem[depth_ff[IDX_W-1:0]]  <= push_pay;
         stack_kind_mem[depth_ff[IDX_W-1:0]] <= push_kind;
      end
      if (cmd.pop_read) begin
         top_pay_ff  <= stack_pay_mem[depth_m1[IDX_W-1:0]];
         top_kind_ff <= stack_kind_mem[depth_m1[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tuser;
         pay_ff   <= req_tdata[39:0];
         kind_ff  <= req_tdata[47:40];
         delay_ff <= req_tdata[70:48];
         code_ff  <= req_tdata[78:71];
      end
      if (cmd.scan_run) begin
         proc_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
   end

   assign count_wide = {5'b0, depth_ff};

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = pop_hit_ff;
      rsp_data_in[40:1]  = pop_hit_ff ? top_pay_ff : '0;
      rsp_data_in[48:41] = pop_hit_ff ? top_kind_ff : '0;
      rsp_data_in[49]    = drop_ff;
      rsp_data_in[54:50] = count_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         depth_ff     <= '0;
         rd_idx_ff    <= '0;
         proc_vld_ff  <= 1'b0;
         placed_ff    <= 1'b0;
         drop_ff      <= 1'b0;
         pop_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff     <= used_in;
         depth_ff    <= depth_in;
         rd_idx_ff   <= rd_idx_in;
         proc_vld_ff <= proc_vld_in;
         placed_ff   <= placed_in;
         drop_ff     <= drop_in;
         pop_hit_ff  <= pop_hit_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/delayed_key_scheduler.sv */
// Top level of the delayed key scheduler: controller joined to datapath.
//
// Commands arrive as beats on the req_ channel; req_tuser holds the command
// and req_tdata the key payload, type, delay and cancel code. Every accepted
// beat yields exactly one beat on the rsp_ channel carrying the pop result,
// the drop flag and the stack occupancy.
// Schedule, cancel and tick walk the slot table one slot per cycle through
// a registered memory read before the result is loaded. Pop and push pass
// through a state of their own before the response state, and any other
// command goes straight to it. One command is handled at a time; a new beat
// is taken as soon as the previous result sits in the output register.
// Reset clears the slot flags, the stack depth and the output valid flag;
// the stores themselves are not cleared.
// While the receiver holds rsp_tready low the result stays registered, and
// one further command may be accepted and worked on, waiting before its own
// result is loaded.
module delayed_key_scheduler_core #(
   parameter int ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata fields from bit 0: key_payload, key_type, delay_ticks, cancel_code
   input  logic [dks_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser fields from bit 0: command
   input  logic [dks_pkg::OP_W-1:0]       req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // rsp_tdata fields from bit 0: pop_valid, pop_payload, pop_type, dropped, stack_count
   output logic [dks_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready
);

   dks_pkg::dks_cmd_type  cmd;
   dks_pkg::dks_stat_type stat;

   dks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dks_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
